// ===== rtl/gbfs_pkg.sv =====
// gbfs_pkg: shared types and constants for the grid shortest path unit
// no dependencies
package gbfs_pkg;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CELL_W = ROW_W + COL_W;
  localparam int CELLS  = 1 << CELL_W;
  localparam int CNT_W  = CELL_W + 1;
  localparam int DIM_W  = 7;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    REG_ROWS = 2'd0,
    REG_COLS = 2'd1
  } reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_CLEAR,
    ST_CHECK0,
    ST_CHECK1,
    ST_CHECK2,
    ST_DEQ0,
    ST_DEQ1,
    ST_NB0,
    ST_NB1,
    ST_NB2,
    ST_CNT0,
    ST_CNT1,
    ST_FILL0,
    ST_FILL1,
    ST_READ0,
    ST_READ1,
    ST_RESP
  } state_t;
endpackage

// ===== rtl/grid_bfs_shortest_path_unit.sv =====
// grid_bfs_shortest_path_unit: grid breadth-first shortest path search engine
// depends on gbfs_pkg
//
// channel   dir  bits  content
// s_axis    in   40    request: action, row, col, blocked, target row/col, step index
// m_axis    out  32    response: found, distance, step row, step col, step valid
// cfg       in   7     grid_rows (index 0), grid_cols (index 1)
//
// a load goes from the accept straight to the response, and a read fetches the
// path step through READ0 and READ1 before it; a search clears the visited map,
// checks the start and target cells, dequeues cells and tries their four
// neighbours, then walks the parent directions back from the target twice
// (count and fill). rst is synchronous; after reset a clearing pass over every
// cell clears the obstacle map before the first request is taken. no request is
// taken until the response has been delivered.
module grid_bfs_shortest_path_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] action, [7:2] row_in, [13:8] col_in, [14] blocked_in,
  // [20:15] target_row, [26:21] target_col, [38:27] step_index, zero pad
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] found, [12:1] distance, [18:13] step_row, [24:19] step_col,
  // [25] step_valid, zero pad
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam int CW = gbfs_pkg::CELL_W;
  localparam int NW = gbfs_pkg::CNT_W;

  gbfs_pkg::state_t state, state_next;

  // configuration
  logic [gbfs_pkg::DIM_W-1:0] grid_rows, grid_cols;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= 7'd64;
      grid_cols <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == 1'(gbfs_pkg::REG_ROWS)) grid_rows <= cfg_data;
      else grid_cols <= cfg_data;
    end
  end
  logic [gbfs_pkg::DIM_W-1:0] rows_use, cols_use;
  assign rows_use = (grid_rows > 7'd64) ? 7'd64 : grid_rows;
  assign cols_use = (grid_cols > 7'd64) ? 7'd64 : grid_cols;

  // request fields
  logic [5:0]  req_r, req_c, req_tr, req_tc;
  logic [11:0] req_idx;

  // memories
  logic              obst_mem [gbfs_pkg::CELLS];
  logic              vis_mem  [gbfs_pkg::CELLS];
  logic [1:0]        par_mem  [gbfs_pkg::CELLS];
  logic [CW-1:0]     q_mem    [gbfs_pkg::CELLS];
  logic [CW-1:0]     path_mem [gbfs_pkg::CELLS];

  logic [CW-1:0] addr;          // shared cell address for obstacle/visited/parent
  logic          obst_q, vis_q;
  logic [1:0]    par_q;
  logic [CW-1:0] q_q, path_q;

  logic [CW-1:0] q_head;
  logic [NW-1:0] q_tail;
  logic [NW-1:0] path_len, len;
  logic          path_found;
  logic [CW-1:0] start_c, target_c, here, cur;
  logic [1:0]    dir;
  logic [NW-1:0] k;
  logic [CW-1:0] clr;
  logic [31:0]   resp, resp_next;

  // neighbour of here in direction dir (single shared adder/compare)
  logic [6:0] nr, nc;
  logic       n_in;
  always_comb begin
    nr = {1'b0, here[CW-1:6]};
    nc = {1'b0, here[5:0]};
    unique case (gbfs_pkg::dir_t'(dir))
      gbfs_pkg::DIR_UP:    nr = nr - 7'd1;
      gbfs_pkg::DIR_DOWN:  nr = nr + 7'd1;
      gbfs_pkg::DIR_LEFT:  nc = nc - 7'd1;
      gbfs_pkg::DIR_RIGHT: nc = nc + 7'd1;
    endcase
    n_in = (nr < rows_use) && (nc < cols_use);
  end

  // parent of cur: step back against the recorded direction
  logic [CW-1:0] prev;
  always_comb begin
    prev = cur;
    unique case (gbfs_pkg::dir_t'(par_q))
      gbfs_pkg::DIR_UP:    prev = cur + CW'(64);
      gbfs_pkg::DIR_DOWN:  prev = cur - CW'(64);
      gbfs_pkg::DIR_LEFT:  prev = cur + CW'(1);
      gbfs_pkg::DIR_RIGHT: prev = cur - CW'(1);
    endcase
  end

  logic s_ok;
  assign s_ok = (req_r < rows_use[5:0] || rows_use == 7'd64) && (req_c < cols_use[5:0] ||
                cols_use == 7'd64) && (req_tr < rows_use[5:0] || rows_use == 7'd64) &&
                (req_tc < cols_use[5:0] || cols_use == 7'd64);

  // load of an in-grid cell, taken straight off the request bus
  logic l_ok_in;
  assign l_ok_in = ({1'b0, s_axis_tdata[7:2]} < rows_use) &&
                   ({1'b0, s_axis_tdata[13:8]} < cols_use);
  logic load_we;
  assign load_we = (state == gbfs_pkg::ST_IDLE) && s_axis_tvalid &&
                   (s_axis_tdata[1:0] == gbfs_pkg::ACT_LOAD) && l_ok_in;

  // fresh neighbour: mark, record direction, enqueue
  logic enq;
  assign enq = (state == gbfs_pkg::ST_NB1) && !vis_q && !obst_q &&
               (q_tail < NW'(gbfs_pkg::CELLS));

  // last path cell written: the search has found its path
  logic fill_done;
  assign fill_done = (state == gbfs_pkg::ST_FILL1) && (cur == start_c || k == NW'(1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      gbfs_pkg::ST_IDLE:
        if (s_axis_tvalid) begin
          unique case (gbfs_pkg::action_t'(s_axis_tdata[1:0]))
            gbfs_pkg::ACT_SEARCH: state_next = gbfs_pkg::ST_CLEAR;
            gbfs_pkg::ACT_READ:   state_next = gbfs_pkg::ST_READ0;
            gbfs_pkg::ACT_LOAD, gbfs_pkg::ACT_NONE: state_next = gbfs_pkg::ST_RESP;
          endcase
        end
      gbfs_pkg::ST_INIT:   if (&clr) state_next = gbfs_pkg::ST_IDLE;
      gbfs_pkg::ST_CLEAR:  if (&clr) state_next = gbfs_pkg::ST_CHECK0;
      gbfs_pkg::ST_CHECK0: state_next = s_ok ? gbfs_pkg::ST_CHECK1 : gbfs_pkg::ST_RESP;
      // start obstacle flag is in obst_q here
      gbfs_pkg::ST_CHECK1: state_next = obst_q ? gbfs_pkg::ST_RESP : gbfs_pkg::ST_CHECK2;
      // target obstacle flag is in obst_q here
      gbfs_pkg::ST_CHECK2: state_next = obst_q ? gbfs_pkg::ST_RESP : gbfs_pkg::ST_DEQ0;
      gbfs_pkg::ST_DEQ0:
        state_next = ({1'b0, q_head} < q_tail) ? gbfs_pkg::ST_DEQ1 : gbfs_pkg::ST_CNT0;
      gbfs_pkg::ST_DEQ1:
        state_next = (q_q == target_c) ? gbfs_pkg::ST_CNT0 : gbfs_pkg::ST_NB0;
      gbfs_pkg::ST_NB0:    state_next = n_in ? gbfs_pkg::ST_NB1 : gbfs_pkg::ST_NB2;
      gbfs_pkg::ST_NB1:    state_next = gbfs_pkg::ST_NB2;
      gbfs_pkg::ST_NB2:
        state_next = (dir == gbfs_pkg::DIR_RIGHT) ? gbfs_pkg::ST_DEQ0 : gbfs_pkg::ST_NB0;
      gbfs_pkg::ST_CNT0:   state_next = gbfs_pkg::ST_CNT1;
      gbfs_pkg::ST_CNT1:
        if (!vis_q) state_next = gbfs_pkg::ST_RESP;
        else if (cur == start_c || len >= NW'(gbfs_pkg::CELLS)) state_next = gbfs_pkg::ST_FILL0;
        else state_next = gbfs_pkg::ST_CNT0;
      gbfs_pkg::ST_FILL0:  state_next = gbfs_pkg::ST_FILL1;
      gbfs_pkg::ST_FILL1:  state_next = fill_done ? gbfs_pkg::ST_RESP : gbfs_pkg::ST_FILL0;
      gbfs_pkg::ST_READ0:  state_next = gbfs_pkg::ST_READ1;
      gbfs_pkg::ST_READ1:  state_next = gbfs_pkg::ST_RESP;
      gbfs_pkg::ST_RESP:   if (m_axis_tready) state_next = gbfs_pkg::ST_IDLE;
      default:             state_next = gbfs_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = (state == gbfs_pkg::ST_IDLE);
    m_axis_tvalid = (state == gbfs_pkg::ST_RESP);
    m_axis_tdata  = resp;
  end

  // shared address selection
  logic [CW-1:0] n_cell;
  assign n_cell = {nr[5:0], nc[5:0]};
  always_comb begin
    unique case (state)
      gbfs_pkg::ST_CHECK0: addr = start_c;
      gbfs_pkg::ST_CHECK1: addr = target_c;
      gbfs_pkg::ST_NB0, gbfs_pkg::ST_NB1: addr = n_cell;
      default: addr = cur;
    endcase
  end

  // memory ports
  always_ff @(posedge clk) begin
    obst_q <= obst_mem[addr];
    vis_q  <= vis_mem[addr];
    par_q  <= par_mem[addr];
    q_q    <= q_mem[q_head];
    path_q <= path_mem[req_idx];
    if (state == gbfs_pkg::ST_CLEAR) vis_mem[clr] <= 1'b0;
    else if (state == gbfs_pkg::ST_CHECK2 && !obst_q) vis_mem[start_c] <= 1'b1;
    else if (enq) vis_mem[addr] <= 1'b1;
    if (enq) par_mem[addr] <= dir;
    if (state == gbfs_pkg::ST_CHECK2 && !obst_q) q_mem[q_tail[CW-1:0]] <= start_c;
    else if (enq) q_mem[q_tail[CW-1:0]] <= addr;
    if (state == gbfs_pkg::ST_FILL1) path_mem[CW'(k - NW'(1))] <= cur;
    // clearing pass after reset makes every cell walkable
    if (state == gbfs_pkg::ST_INIT) obst_mem[clr] <= 1'b0;
    else if (load_we) obst_mem[{s_axis_tdata[7:2], s_axis_tdata[13:8]}] <= s_axis_tdata[14];
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbfs_pkg::ST_INIT;
      path_found <= 1'b0;
      path_len   <= '0;
      q_head     <= '0;
      q_tail     <= '0;
      clr        <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        gbfs_pkg::ST_IDLE:
          if (s_axis_tvalid) begin
            req_r   <= s_axis_tdata[7:2];
            req_c   <= s_axis_tdata[13:8];
            req_tr  <= s_axis_tdata[20:15];
            req_tc  <= s_axis_tdata[26:21];
            req_idx <= s_axis_tdata[38:27];
            start_c  <= {s_axis_tdata[7:2], s_axis_tdata[13:8]};
            target_c <= {s_axis_tdata[20:15], s_axis_tdata[26:21]};
            clr <= '0;
            if (s_axis_tdata[1:0] == gbfs_pkg::ACT_SEARCH) begin
              path_found <= 1'b0;
              path_len   <= '0;
              q_head     <= '0;
              q_tail     <= '0;
            end
          end
        gbfs_pkg::ST_INIT:  clr <= clr + CW'(1);
        gbfs_pkg::ST_CLEAR: clr <= clr + CW'(1);
        gbfs_pkg::ST_CHECK2:
          if (!obst_q) q_tail <= NW'(1);
        gbfs_pkg::ST_DEQ0: begin
          cur <= target_c;
          len <= NW'(1);
        end
        gbfs_pkg::ST_DEQ1: begin
          here   <= q_q;
          q_head <= q_head + CW'(1);
          dir    <= gbfs_pkg::DIR_UP;
        end
        gbfs_pkg::ST_NB1:
          if (enq) q_tail <= q_tail + NW'(1);
        gbfs_pkg::ST_NB2: dir <= dir + 2'd1;
        gbfs_pkg::ST_CNT1:
          if (vis_q) begin
            if (cur == start_c || len >= NW'(gbfs_pkg::CELLS)) begin
              cur <= target_c;
              k   <= len;
            end else begin
              cur <= prev;
              len <= len + NW'(1);
            end
          end
        gbfs_pkg::ST_FILL1:
          if (fill_done) begin
            path_found <= 1'b1;
            path_len   <= len;
          end else begin
            cur <= prev;
            k   <= k - NW'(1);
          end
        default: ;
      endcase
    end
  end

  // response word, built once the request has finished
  logic [11:0] dist_val;
  assign dist_val = path_found ? 12'(path_len - NW'(1)) : 12'd0;
  logic rd_ok;
  assign rd_ok = path_found && ({1'b0, req_idx} < path_len);
  always_comb begin
    resp_next       = '0;
    resp_next[0]    = path_found | fill_done;
    resp_next[12:1] = fill_done ? 12'(len - NW'(1)) : dist_val;
    if (state == gbfs_pkg::ST_READ1 && rd_ok) begin
      resp_next[18:13] = path_q[CW-1:6];
      resp_next[24:19] = path_q[5:0];
      resp_next[25]    = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (state != gbfs_pkg::ST_RESP) resp <= resp_next;
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != gbfs_pkg::ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    q_tail <= NW'(gbfs_pkg::CELLS)) else $error("queue overflow");
  a_head: assert property (@(posedge clk) disable iff (rst)
    (state == gbfs_pkg::ST_DEQ1) |-> ({1'b0, q_head} < q_tail)) else $error("queue underflow");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("response dropped or changed while stalled");
endmodule

// ===== sim/grid_bfs_shortest_path_unit_test.sv =====
// testbench for grid_bfs_shortest_path_unit: loads grids, runs searches, reads path steps
// depends on gbfs_pkg and the unit; every response is checked against an in-bench predictor
`timescale 1ns / 1ps

module grid_bfs_shortest_path_unit_test;

  localparam int WATCHDOG = 500000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [1:0] action, [7:2] row_in, [13:8] col_in, [14] blocked_in,
  // [20:15] target_row, [26:21] target_col, [38:27] step_index, zero pad
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] found, [12:1] distance, [18:13] step_row, [24:19] step_col,
  // [25] step_valid, zero pad
  logic [31:0] m_axis_tdata;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [6:0]  cfg_data;

  grid_bfs_shortest_path_unit uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    gbfs_pkg::action_t           act;
    logic [gbfs_pkg::ROW_W-1:0]  row;
    logic [gbfs_pkg::COL_W-1:0]  col;
    logic                        blk;
    logic [gbfs_pkg::ROW_W-1:0]  trow;
    logic [gbfs_pkg::COL_W-1:0]  tcol;
    logic [11:0]                 idx;
  } request_t;

  typedef struct packed {
    logic                        found;
    logic [11:0]                 distance;
    logic [gbfs_pkg::ROW_W-1:0]  srow;
    logic [gbfs_pkg::COL_W-1:0]  scol;
    logic                        svalid;
  } response_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    request_t  req;
    bit        fixed;
    response_t ans;
  } vector_t;

  // predictor copy of the block state
  logic [gbfs_pkg::DIM_W-1:0] rows_reg, cols_reg;
  bit               wall[gbfs_pkg::CELLS];
  bit               seen[gbfs_pkg::CELLS];
  logic [1:0]       came_from[gbfs_pkg::CELLS];
  logic [11:0]      fifo_q[gbfs_pkg::CELLS];
  logic [11:0]      route[gbfs_pkg::CELLS];
  int               route_len;
  bit               route_ok;

  response_t        pending_resp[$];
  int               errors;
  int               idle_cycles;
  bit               hold_off;

  function automatic bit on_grid(int r, int c);
    int nr, nc;
    nr = rows_reg > 64 ? 64 : rows_reg;
    nc = cols_reg > 64 ? 64 : cols_reg;
    return r >= 0 && c >= 0 && r < nr && c < nc;
  endfunction

  function automatic int drow(int d);
    return d == gbfs_pkg::DIR_UP ? -1 : (d == gbfs_pkg::DIR_DOWN ? 1 : 0);
  endfunction
  function automatic int dcol(int d);
    return d == gbfs_pkg::DIR_LEFT ? -1 : (d == gbfs_pkg::DIR_RIGHT ? 1 : 0);
  endfunction

  task automatic bfs_search(int sr, int sc, int tr, int tc);
    int start, goal, head, tail, here, hr, hc, nr, nc, n, cur, k;
    route_ok = 0;
    route_len = 0;
    foreach (seen[i]) seen[i] = 0;
    if (!on_grid(sr, sc) || !on_grid(tr, tc)) return;
    start = sr * 64 + sc;
    goal = tr * 64 + tc;
    if (wall[start] || wall[goal]) return;
    head = 0;
    tail = 0;
    fifo_q[tail++] = 12'(start);
    seen[start] = 1;
    while (head < tail) begin
      here = fifo_q[head++];
      if (here == goal) break;
      hr = here / 64;
      hc = here % 64;
      for (int d = 0; d < 4; d++) begin
        nr = hr + drow(d);
        nc = hc + dcol(d);
        if (!on_grid(nr, nc)) continue;
        n = nr * 64 + nc;
        if (seen[n] || wall[n] || tail >= gbfs_pkg::CELLS) continue;
        seen[n] = 1;
        came_from[n] = 2'(d);
        fifo_q[tail++] = 12'(n);
      end
    end
    if (!seen[goal]) return;
    // walk back once to size the path, then again to fill it
    k = 1;
    cur = goal;
    while (cur != start && k < gbfs_pkg::CELLS) begin
      cur = (cur / 64 - drow(came_from[cur])) * 64 + (cur % 64 - dcol(came_from[cur]));
      k++;
    end
    route_len = k;
    cur = goal;
    for (int j = k; j > 0; j--) begin
      route[j-1] = 12'(cur);
      if (cur == start) break;
      cur = (cur / 64 - drow(came_from[cur])) * 64 + (cur % 64 - dcol(came_from[cur]));
    end
    route_ok = 1;
  endtask

  task automatic predict_response(request_t q, output response_t a);
    a = '0;
    case (q.act)
      gbfs_pkg::ACT_LOAD: if (on_grid(q.row, q.col)) wall[q.row * 64 + q.col] = q.blk;
      gbfs_pkg::ACT_SEARCH: bfs_search(q.row, q.col, q.trow, q.tcol);
      gbfs_pkg::ACT_READ: if (route_ok && q.idx < route_len) begin
        a.srow = route[q.idx][11:6];
        a.scol = route[q.idx][5:0];
        a.svalid = 1;
      end
      default: ;
    endcase
    a.found = route_ok;
    a.distance = route_ok ? 12'(route_len - 1) : 12'd0;
  endtask

  function automatic logic [39:0] pack_req(request_t q);
    return {1'b0, q.idx, q.tcol, q.trow, q.blk, q.col, q.row, q.act};
  endfunction

  function automatic request_t mk(gbfs_pkg::action_t a, int r, int c, int b, int tr, int tc,
                                  int i);
    request_t q;
    q.act = a; q.row = 6'(r); q.col = 6'(c); q.blk = 1'(b);
    q.trow = 6'(tr); q.tcol = 6'(tc); q.idx = 12'(i);
    return q;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 19) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 3);
  endfunction

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // response side: random stall, one long hold-off on request
  initial begin
    int g;
    m_axis_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      g = gap_len();
      if (g == 0) m_axis_tready <= 1;
      else begin
        m_axis_tready <= 0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  // checker, sampled at the rising edge
  always @(posedge clk) begin
    response_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{found: m_axis_tdata[0], distance: m_axis_tdata[12:1],
              srow: m_axis_tdata[18:13], scol: m_axis_tdata[24:19],
              svalid: m_axis_tdata[25]};
      if (pending_resp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_resp.pop_front();
        if (got.found !== want.found)
          $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
        if (got.distance !== want.distance)
          $display("%0t: distance exp %0d got %0d", $time, want.distance, got.distance);
        if (got.srow !== want.srow)
          $display("%0t: step_row exp %0d got %0d", $time, want.srow, got.srow);
        if (got.scol !== want.scol)
          $display("%0t: step_col exp %0d got %0d", $time, want.scol, got.scol);
        if (got.svalid !== want.svalid)
          $display("%0t: step_valid exp %0d got %0d", $time, want.svalid, got.svalid);
        if (got !== want) errors++;
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // drive one request; the predictor runs when it is accepted
  task automatic send_request(request_t q);
    response_t a;
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= pack_req(q);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_response(q, a);
    pending_resp.insert(pending_resp.size(), a);
    @(negedge clk);
  endtask

  task automatic drain_and_quiet();
    s_axis_tvalid <= 0;
    while (pending_resp.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(gbfs_pkg::reg_t r, int v);
    cfg_we <= 1;
    cfg_index <= 1'(r);
    cfg_data <= 7'(v);
    @(negedge clk);
    cfg_we <= 0;
    if (r == gbfs_pkg::REG_ROWS) rows_reg = 7'(v); else cols_reg = 7'(v);
  endtask

  // one random request, mostly on the small grid in use
  function automatic request_t rand_req(int nr, int nc);
    request_t q;
    int p;
    q = '0;
    q.row = 6'($urandom_range(0, 63));
    q.col = 6'($urandom_range(0, 63));
    q.trow = 6'($urandom_range(0, 63));
    q.tcol = 6'($urandom_range(0, 63));
    q.idx = 12'($urandom_range(0, 4095));
    q.blk = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 9) != 0) begin
      q.row = 6'($urandom_range(0, nr - 1));
      q.col = 6'($urandom_range(0, nc - 1));
      q.trow = 6'($urandom_range(0, nr - 1));
      q.tcol = 6'($urandom_range(0, nc - 1));
      q.idx = 12'($urandom_range(0, nr + nc));
      q.blk = $urandom_range(0, 3) == 0;
    end
    p = $urandom_range(0, 19);
    q.act = p < 8 ? gbfs_pkg::ACT_LOAD : (p < 12 ? gbfs_pkg::ACT_SEARCH :
            (p < 19 ? gbfs_pkg::ACT_READ : gbfs_pkg::ACT_NONE));
    return q;
  endfunction

  initial begin
    vector_t vec[$];
    vector_t v;
    int sizes[4][2];
    errors = 0;
    hold_off = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    rows_reg = 64;
    cols_reg = 64;
    foreach (wall[i]) wall[i] = 0;
    route_ok = 0;
    route_len = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed part on the full reset grid
    v.fixed = 1; v.ans = '0;
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);          // no path yet
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_NONE, 63, 63, 1, 63, 63, 4095);   // unused action
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_SEARCH, 5, 5, 0, 5, 5, 0);
    v.ans = '{found: 1, distance: 0, srow: 0, scol: 0, svalid: 0};
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    v.ans = '{found: 1, distance: 0, srow: 5, scol: 5, svalid: 1};
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 1);
    v.ans = '{found: 1, distance: 0, srow: 0, scol: 0, svalid: 0};
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 0, 63, 0);
    v.ans = '{found: 1, distance: 63, srow: 0, scol: 0, svalid: 0};
    vec.insert(vec.size(), v);
    v.fixed = 0;
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 63);         vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 4095);       vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_LOAD, 63, 63, 1, 0, 0, 0);        vec.insert(vec.size(), v);
    v.fixed = 1; v.ans = '0;
    v.req = mk(gbfs_pkg::ACT_SEARCH, 63, 63, 0, 0, 0, 0);      // blocked start
    vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_SEARCH, 0, 62, 0, 63, 63, 0);     // blocked target
    vec.insert(vec.size(), v);
    v.fixed = 0;
    v.req = mk(gbfs_pkg::ACT_LOAD, 63, 63, 0, 0, 0, 0);        vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_LOAD, 1, 0, 1, 0, 0, 0);          vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_LOAD, 0, 1, 1, 0, 0, 0);          vec.insert(vec.size(), v);
    v.fixed = 1;
    v.req = mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 2, 2, 0);        // walled in
    vec.insert(vec.size(), v);
    v.fixed = 0;
    v.req = mk(gbfs_pkg::ACT_LOAD, 0, 1, 0, 0, 0, 0);          vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 2, 2, 0);        vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_READ, 0, 0, 0, 0, 0, 2);          vec.insert(vec.size(), v);
    v.req = mk(gbfs_pkg::ACT_LOAD, 1, 0, 0, 0, 0, 0);          vec.insert(vec.size(), v);
    foreach (vec[i]) begin
      response_t a;
      send_request(vec[i].req);
      a = pending_resp[$];
      if (vec[i].fixed && a !== vec[i].ans) begin
        $display("%0t: directed row %0d exp %h predicted %h", $time, i, vec[i].ans, a);
        errors++;
      end
      if (vec[i].fixed) pending_resp[$] = vec[i].ans;
    end
    drain_and_quiet();

    // small grid out of range of the loads, then an empty grid
    write_reg(gbfs_pkg::REG_ROWS, 4);
    write_reg(gbfs_pkg::REG_COLS, 3);
    send_request(mk(gbfs_pkg::ACT_LOAD, 5, 1, 1, 0, 0, 0));
    send_request(mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 3, 2, 0));
    send_request(mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 4, 0, 0));
    drain_and_quiet();
    write_reg(gbfs_pkg::REG_ROWS, 0);
    write_reg(gbfs_pkg::REG_COLS, 127);
    send_request(mk(gbfs_pkg::ACT_LOAD, 0, 0, 1, 0, 0, 0));
    send_request(mk(gbfs_pkg::ACT_SEARCH, 0, 0, 0, 0, 0, 0));
    drain_and_quiet();

    // random phases over several grid sizes
    sizes = '{'{6, 5}, '{1, 8}, '{8, 1}, '{10, 12}};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(gbfs_pkg::REG_ROWS, sizes[ph][0]);
      write_reg(gbfs_pkg::REG_COLS, sizes[ph][1]);
      for (int n = 0; n < 25; n++) begin
        if (ph == 3 && n == 5) hold_off = 1;
        send_request(rand_req(sizes[ph][0], sizes[ph][1]));
      end
      drain_and_quiet();
    end

    // the end
    repeat (50) @(negedge clk);
    if (errors == 0 && pending_resp.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
